>>> hw/rtl/mexp_pkg.sv
package mexp_pkg;

	// width of the base, exponent, modulus and residue ports
	localparam int DATA_W = 32;

	// width of the arithmetic and number of exponent bits walked
	localparam int OPERAND_BITS = 32;

	// counter over the operand bits
	localparam int CNT_W = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_SQR  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} mexp_state_t;

	// start of one modular multiply on the shared unit
	typedef struct packed {
		logic                    start;
		logic [OPERAND_BITS-1:0] a;
		logic [OPERAND_BITS-1:0] b;
	} mexp_mm_req_t;

endpackage

>>> hw/rtl/modular_exponentiation.sv
// Computes base^exponent mod modulus on 32-bit unsigned operands, one request at a time.
// A zero modulus returns residue 0 with div_error set, via the final state and no multiply.
// Otherwise the base is first reduced, then the exponent is walked from its top bit by
// square-and-multiply; every modular multiply runs on one shared bit-serial unit.
// in_stall is high from acceptance until the result has been moved to the output
// register, which holds it until taken, so the next request can be accepted while a
// result still waits.
module modular_exponentiation import mexp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] base,
	input  logic [DATA_W-1:0] exponent,
	input  logic [DATA_W-1:0] modulus,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] residue,
	output logic              div_error
);

	mexp_state_t             state_q;
	logic [OPERAND_BITS-1:0] exp_q;
	logic [OPERAND_BITS-1:0] mod_q;
	logic [OPERAND_BITS-1:0] bred_q;
	logic [OPERAND_BITS-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    err_q;
	logic                    out_valid_q;
	logic [DATA_W-1:0]       residue_q;
	logic                    div_error_q;

	logic [OPERAND_BITS-1:0] base_op;
	logic [OPERAND_BITS-1:0] mod_op;
	logic [OPERAND_BITS-1:0] one_in;
	logic [OPERAND_BITS-1:0] one_q;
	mexp_mm_req_t            mm_req;
	logic                    mm_done;
	logic [OPERAND_BITS-1:0] mm_prod;

	// operands in their low operand bits, and 1 mod m
	always_comb begin
		base_op = OPERAND_BITS'(base);
		mod_op  = OPERAND_BITS'(modulus);
		one_in  = (mod_op == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
		one_q   = (mod_q == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
	end

	// launch of the next multiply
	always_comb begin
		mm_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && mod_op != '0) begin
					mm_req.start = 1'b1;
					mm_req.a     = one_in;
					mm_req.b     = base_op;
				end
			end
			ST_RED: begin
				if (mm_done) begin
					mm_req.start = 1'b1;
					mm_req.a     = one_q;
					mm_req.b     = one_q;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					if (exp_q[OPERAND_BITS-1]) begin
						mm_req.start = 1'b1;
						mm_req.a     = mm_prod;
						mm_req.b     = bred_q;
					end else if (cnt_q != '0) begin
						mm_req.start = 1'b1;
						mm_req.a     = mm_prod;
						mm_req.b     = mm_prod;
					end
				end
			end
			ST_MUL: begin
				if (mm_done && cnt_q != '0) begin
					mm_req.start = 1'b1;
					mm_req.a     = mm_prod;
					mm_req.b     = mm_prod;
				end
			end
			default: begin
				mm_req = '0;
			end
		endcase
	end

	// shared modular multiplier
	mexp_mmul u_mmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.m      (mod_q),
		.done   (mm_done),
		.prod   (mm_prod)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			mod_q       <= '0;
			bred_q      <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			residue_q   <= '0;
			div_error_q <= 1'b0;
		end else begin
			// taken result leaves, unless the final state refills the register
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						exp_q   <= OPERAND_BITS'(exponent);
						mod_q   <= mod_op;
						cnt_q   <= CNT_W'(OPERAND_BITS - 1);
						acc_q   <= '0;
						err_q   <= (mod_op == '0);
						state_q <= (mod_op == '0) ? ST_FIN : ST_RED;
					end
				end
				ST_RED: begin
					if (mm_done) begin
						bred_q  <= mm_prod;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_done) begin
						acc_q <= mm_prod;
						if (exp_q[OPERAND_BITS-1]) begin
							state_q <= ST_MUL;
						end else if (cnt_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							exp_q <= {exp_q[OPERAND_BITS-2:0], 1'b0};
						end
					end
				end
				ST_MUL: begin
					if (mm_done) begin
						acc_q <= mm_prod;
						if (cnt_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							cnt_q   <= cnt_q - 1'b1;
							exp_q   <= {exp_q[OPERAND_BITS-2:0], 1'b0};
							state_q <= ST_SQR;
						end
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						residue_q   <= err_q ? '0 : DATA_W'(acc_q);
						div_error_q <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign residue   = residue_q;
	assign div_error = div_error_q;

endmodule

>>> hw/rtl/mexp_mmul.sv
// bit-serial modular multiply: one double-and-add step per cycle
module mexp_mmul import mexp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mexp_mm_req_t            req,
	input  logic [OPERAND_BITS-1:0] m,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] prod
);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [OPERAND_BITS-1:0] a_q;
	logic [OPERAND_BITS-1:0] b_q;
	logic [OPERAND_BITS-1:0] acc_q;

	logic [OPERAND_BITS-1:0] a_sel;
	logic [OPERAND_BITS+1:0] sum;
	logic [OPERAND_BITS+1:0] m_one;
	logic [OPERAND_BITS+1:0] m_two;
	logic [OPERAND_BITS+1:0] red;

	// acc = (2*acc + bit*a) mod m, the sum stays below 3*m
	always_comb begin
		a_sel = b_q[OPERAND_BITS-1] ? a_q : '0;
		sum   = {1'b0, acc_q, 1'b0} + {2'b00, a_sel};
		m_one = {2'b00, m};
		m_two = {1'b0, m, 1'b0};
		if (sum >= m_two) begin
			red = sum - m_two;
		end else if (sum >= m_one) begin
			red = sum - m_one;
		end else begin
			red = sum;
		end
	end

	// operand capture and step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OPERAND_BITS - 1);
				a_q    <= req.a;
				b_q    <= req.b;
				acc_q  <= '0;
			end else if (busy_q) begin
				acc_q <= red[OPERAND_BITS-1:0];
				b_q   <= {b_q[OPERAND_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> hw/rtl/mexp_checker.sv
// port-level checks on the modular exponentiation block
module mexp_checker import mexp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DATA_W-1:0] residue,
	input logic              div_error
);

	// an accepted request makes the block busy in the next cycle
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while block stays ready");

	// a new result only appears while a request is in work
	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in work");

	// an error result carries a zero residue
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |-> residue == '0)
		else $error("error result with nonzero residue");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(residue) && $stable(div_error))
		else $error("stalled result changed");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.residue   (residue),
	.div_error (div_error)
);
